@@ sv/cfbtp_pkg.sv @@
// Shared types, constants and the frame cost table for the CAN frame batch pacer.
package cfbtp_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_FRAME = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_RESET = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [1:0] REG_PACE_ENABLE     = 2'd0;
    localparam logic [1:0] REG_TOKENS_PER_TICK = 2'd1;
    localparam logic [1:0] REG_BUCKET_CAP      = 2'd2;
    localparam logic [1:0] REG_HOLDOFF_TICKS   = 2'd3;

    // Batch limits and reset values
    localparam logic [3:0]  BATCH_MAX        = 4'd12;
    localparam logic [12:0] BATCH_BITS_MAX   = 13'd8191;
    localparam logic [15:0] AVG_RESET        = 16'd9600;
    localparam logic [15:0] TPT_RESET        = 16'd243;
    localparam logic [31:0] CAP_RESET        = 32'd3648000;
    localparam logic [15:0] HOLDOFF_RESET    = 16'd3000;

    typedef struct packed {
        logic        pace_enable;
        logic [15:0] tokens_per_tick;
        logic [31:0] bucket_cap;
        logic [15:0] holdoff_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] dlc;
        logic       extended;
    } item_t;

    // Result beat, last member in the lowest bits
    typedef struct packed {
        logic [9:0]  avg_bits;
        logic        rx_paused;
        logic [12:0] flush_bits;
        logic [3:0]  flush_frames;
        logic        flushed;
        logic [9:0]  frame_bits;
        logic        accepted;
    } result_t;

    // Wire bits of one frame: fixed header bits plus 8 per byte, plus 6.5 percent stuffing
    // on everything past the 13 unstuffed bits, rounded down.
    function automatic logic [9:0] wire_cost(input logic [3:0] dlc, input logic extended);
        logic [9:0] std_bits;
        logic [9:0] ext_bits;
        case (dlc)
            4'd0:    begin std_bits = 10'd49;  ext_bits = 10'd70;  end
            4'd1:    begin std_bits = 10'd57;  ext_bits = 10'd79;  end
            4'd2:    begin std_bits = 10'd66;  ext_bits = 10'd87;  end
            4'd3:    begin std_bits = 10'd74;  ext_bits = 10'd96;  end
            4'd4:    begin std_bits = 10'd83;  ext_bits = 10'd104; end
            4'd5:    begin std_bits = 10'd91;  ext_bits = 10'd113; end
            4'd6:    begin std_bits = 10'd100; ext_bits = 10'd121; end
            4'd7:    begin std_bits = 10'd108; ext_bits = 10'd130; end
            4'd8:    begin std_bits = 10'd117; ext_bits = 10'd138; end
            4'd9:    begin std_bits = 10'd151; ext_bits = 10'd172; end
            4'd10:   begin std_bits = 10'd185; ext_bits = 10'd206; end
            4'd11:   begin std_bits = 10'd219; ext_bits = 10'd240; end
            4'd12:   begin std_bits = 10'd253; ext_bits = 10'd274; end
            4'd13:   begin std_bits = 10'd321; ext_bits = 10'd343; end
            4'd14:   begin std_bits = 10'd458; ext_bits = 10'd479; end
            default: begin std_bits = 10'd594; ext_bits = 10'd615; end
        endcase
        return extended ? ext_bits : std_bits;
    endfunction

endpackage

@@ sv/cfbtp_engine.sv @@
// Batch, average, hold-off and token bucket state with the per-item update logic.
module cfbtp_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  cfbtp_pkg::item_t   item,
    input  cfbtp_pkg::cfg_t    cfg,
    output cfbtp_pkg::result_t result
);

    logic [3:0]  batch_count_reg, batch_count_next;
    logic [12:0] batch_bits_reg, batch_bits_next;
    logic [31:0] tokens_reg, tokens_next;
    logic [15:0] avg_scaled_reg, avg_scaled_next;
    logic [15:0] holdoff_count_reg, holdoff_count_next;
    logic        holdoff_armed_reg, holdoff_armed_next;
    logic        pending_reg, pending_next;

    logic [9:0]  cost;
    logic [13:0] bits_sum;
    logic [32:0] tokens_sum;
    logic [20:0] need;
    logic        try_send;

    assign cost = cfbtp_pkg::wire_cost(item.dlc, item.extended);

    // Compute next state and the result for the item in the input stage
    always_comb begin
        batch_count_next   = batch_count_reg;
        batch_bits_next    = batch_bits_reg;
        tokens_next        = tokens_reg;
        avg_scaled_next    = avg_scaled_reg;
        holdoff_count_next = holdoff_count_reg;
        holdoff_armed_next = holdoff_armed_reg;
        pending_next       = pending_reg;
        try_send           = 1'b0;
        bits_sum           = {1'b0, batch_bits_reg} + {4'd0, cost};
        tokens_sum         = {1'b0, tokens_reg} + {17'd0, cfg.tokens_per_tick};
        result             = '0;

        unique case (item.mode)
            cfbtp_pkg::MODE_FRAME: begin
                result.frame_bits = cost;
                if (batch_count_reg < cfbtp_pkg::BATCH_MAX) begin
                    result.accepted  = 1'b1;
                    batch_count_next = batch_count_reg + 4'd1;
                    batch_bits_next  = bits_sum[13] ? cfbtp_pkg::BATCH_BITS_MAX
                                                    : bits_sum[12:0];
                    // EWMA with weight 1/64, wraps at 16 bits
                    avg_scaled_next  = avg_scaled_reg + {6'd0, cost}
                                     - {6'd0, avg_scaled_reg[15:6]};
                    if (batch_count_next >= cfbtp_pkg::BATCH_MAX) begin
                        try_send = 1'b1;
                    end else if (!pending_reg && !holdoff_armed_reg) begin
                        holdoff_armed_next = 1'b1;
                        holdoff_count_next = cfg.holdoff_ticks;
                    end
                end
            end
            cfbtp_pkg::MODE_TICK: begin
                // Refill the bucket, clamped to capacity
                tokens_next = (tokens_sum > {1'b0, cfg.bucket_cap}) ? cfg.bucket_cap
                                                                     : tokens_sum[31:0];
                if (pending_reg) begin
                    try_send = 1'b1;
                end else if (holdoff_armed_reg) begin
                    if (holdoff_count_reg <= 16'd1) begin
                        try_send = 1'b1;
                    end else begin
                        holdoff_count_next = holdoff_count_reg - 16'd1;
                    end
                end
            end
            cfbtp_pkg::MODE_RESET: begin
                batch_count_next   = '0;
                batch_bits_next    = '0;
                holdoff_armed_next = 1'b0;
                holdoff_count_next = '0;
                pending_next       = 1'b0;
                tokens_next        = cfg.bucket_cap;
            end
            default: begin
            end
        endcase

        // Release the batch if pacing is off or the bucket covers it, else leave it pending
        need = {batch_bits_next, 8'd0};
        if (try_send) begin
            holdoff_armed_next = 1'b0;
            holdoff_count_next = '0;
            if (batch_count_next != 4'd0) begin
                if (cfg.pace_enable && (tokens_next < {11'd0, need})) begin
                    pending_next = 1'b1;
                end else begin
                    if (cfg.pace_enable) begin
                        tokens_next = tokens_next - {11'd0, need};
                    end
                    result.flushed      = 1'b1;
                    result.flush_frames = batch_count_next;
                    result.flush_bits   = batch_bits_next;
                    batch_count_next    = '0;
                    batch_bits_next     = '0;
                    pending_next        = 1'b0;
                end
            end
        end

        result.rx_paused = pending_next;
        result.avg_bits  = avg_scaled_next[15:6];
    end

    // Commit state when the item moves to the output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_count_reg   <= '0;
            batch_bits_reg    <= '0;
            tokens_reg        <= '0;
            avg_scaled_reg    <= cfbtp_pkg::AVG_RESET;
            holdoff_count_reg <= '0;
            holdoff_armed_reg <= 1'b0;
            pending_reg       <= 1'b0;
        end else if (advance) begin
            batch_count_reg   <= batch_count_next;
            batch_bits_reg    <= batch_bits_next;
            tokens_reg        <= tokens_next;
            avg_scaled_reg    <= avg_scaled_next;
            holdoff_count_reg <= holdoff_count_next;
            holdoff_armed_reg <= holdoff_armed_next;
            pending_reg       <= pending_next;
        end
    end

endmodule

@@ sv/can_frame_batch_token_pacer.sv @@
// CAN frame batcher with token bucket pacing: one result beat for every input beat.
// Each input beat is a frame, a tick, a pacing reset or a no-op (tuser). Beats pass an input register
// and a result register; the whole state update sits between them, so the block takes one
// beat per clock and each result is offered on m_tvalid once the result register takes it,
// with both stages stalling only when the result side holds off tready. The slowest path is
// the tick: bucket refill with clamp, then the batch cost compare and token subtract.
// Configuration writes take effect at once and belong in idle periods.
module can_frame_batch_token_pacer (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] dlc, [4] extended, [7:5] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] accepted, [10:1] frame_bits, [11] flushed,
                                   // [15:12] flush_frames, [28:16] flush_bits,
                                   // [29] rx_paused, [39:30] avg_bits
    // Configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    cfbtp_pkg::cfg_t    cfg_reg;
    cfbtp_pkg::item_t   item_reg;
    logic               in_valid_reg;
    cfbtp_pkg::result_t res_comb;
    cfbtp_pkg::result_t res_reg;
    logic               out_valid_reg;
    logic               advance;

    // Move the input stage forward when the result stage is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pace_enable     <= 1'b1;
            cfg_reg.tokens_per_tick <= cfbtp_pkg::TPT_RESET;
            cfg_reg.bucket_cap      <= cfbtp_pkg::CAP_RESET;
            cfg_reg.holdoff_ticks   <= cfbtp_pkg::HOLDOFF_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cfbtp_pkg::REG_PACE_ENABLE:     cfg_reg.pace_enable     <= cfg_wdata[0];
                cfbtp_pkg::REG_TOKENS_PER_TICK: cfg_reg.tokens_per_tick <= cfg_wdata[15:0];
                cfbtp_pkg::REG_BUCKET_CAP:      cfg_reg.bucket_cap      <= cfg_wdata;
                cfbtp_pkg::REG_HOLDOFF_TICKS:   cfg_reg.holdoff_ticks   <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Capture input beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.mode     <= cfbtp_pkg::mode_t'(s_tuser);
            item_reg.dlc      <= s_tdata[3:0];
            item_reg.extended <= s_tdata[4];
        end
    end

    cfbtp_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (res_comb)
    );

    // Hold the result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_comb;
        end
    end

endmodule
